### hdl/tbmc_pkg.sv
`default_nettype none

package tbmc_pkg;

  // Direction codes of a result.
  localparam logic [3:0] DIR_STAY       = 4'd0;
  localparam logic [3:0] DIR_LEFT       = 4'd1;
  localparam logic [3:0] DIR_RIGHT      = 4'd2;
  localparam logic [3:0] DIR_FRONT      = 4'd3;
  localparam logic [3:0] DIR_BACK       = 4'd4;
  localparam logic [3:0] DIR_LEFTFRONT  = 4'd5;
  localparam logic [3:0] DIR_LEFTBACK   = 4'd6;
  localparam logic [3:0] DIR_RIGHTFRONT = 4'd7;
  localparam logic [3:0] DIR_RIGHTBACK  = 4'd8;

  // Three-way decision along one axis.
  localparam logic [1:0] AX_NONE  = 2'd0;
  localparam logic [1:0] AX_ABOVE = 2'd1;
  localparam logic [1:0] AX_BELOW = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_X_COUNT    = 3'd0;
  localparam logic [2:0] CFG_X_DELAY    = 3'd1;
  localparam logic [2:0] CFG_AREA_COUNT = 3'd2;
  localparam logic [2:0] CFG_AREA_DELAY = 3'd3;
  localparam logic [2:0] CFG_VOTE_SPAN  = 3'd4;
  localparam logic [2:0] CFG_SMOOTHING  = 3'd5;

  // Arithmetic constants.
  localparam int NEAR_TAPS  = 5;
  localparam int THR_SHIFT  = 3;
  localparam int MIN_SCAN   = 64;
  localparam int DIV_W      = 29;
  localparam int DIVISOR_W  = 5;

  // Exact reciprocals for 32-bit unsigned operands: divide by 15, and by 5.
  // The area threshold divides by 4 first and then by 5, giving a division by 20.
  localparam logic [31:0] RECIP15     = 32'h8888_8889;
  localparam int          RECIP15_SH  = 35;
  localparam logic [31:0] RECIP5      = 32'hCCCC_CCCD;
  localparam int          RECIP5_SH   = 34;
  localparam int          AREA_PRE_SH = 2;

  // One history entry held by a cell.
  typedef struct packed {
    logic [11:0] x;
    logic [11:0] w;
    logic [23:0] a;
    logic [3:0]  dir;
  } cell_data_t;

  // Per-cell control.
  typedef struct packed {
    logic shift;
    logic rotate;
    logic set_dir;
  } cell_ctl_t;

  function automatic logic [1:0] lr_of(input logic [3:0] d);
    case (d)
      DIR_LEFT, DIR_LEFTFRONT, DIR_LEFTBACK:     lr_of = AX_ABOVE;
      DIR_RIGHT, DIR_RIGHTFRONT, DIR_RIGHTBACK:  lr_of = AX_BELOW;
      default:                                   lr_of = AX_NONE;
    endcase
  endfunction

  function automatic logic [1:0] fb_of(input logic [3:0] d);
    case (d)
      DIR_FRONT, DIR_LEFTFRONT, DIR_RIGHTFRONT:  fb_of = AX_ABOVE;
      DIR_BACK, DIR_LEFTBACK, DIR_RIGHTBACK:     fb_of = AX_BELOW;
      default:                                   fb_of = AX_NONE;
    endcase
  endfunction

  function automatic logic [3:0] dir_of(input logic [1:0] lr, input logic [1:0] fb);
    logic [3:0] d;
    d = DIR_STAY;
    case (lr)
      AX_ABOVE: begin
        d = (fb == AX_ABOVE) ? DIR_LEFTFRONT : (fb == AX_BELOW) ? DIR_LEFTBACK : DIR_LEFT;
      end
      AX_BELOW: begin
        d = (fb == AX_ABOVE) ? DIR_RIGHTFRONT : (fb == AX_BELOW) ? DIR_RIGHTBACK : DIR_RIGHT;
      end
      default: begin
        d = (fb == AX_ABOVE) ? DIR_FRONT : (fb == AX_BELOW) ? DIR_BACK : DIR_STAY;
      end
    endcase
    dir_of = d;
  endfunction

  // Above when near exceeds avg by more than thr, below when short by more.
  function automatic logic [1:0] cmp3(input logic [23:0] nearv, input logic [23:0] avg,
                                      input logic [23:0] thr);
    logic [1:0] r;
    r = AX_NONE;
    if (nearv > avg && (nearv - avg) > thr) begin
      r = AX_ABOVE;
    end else if (nearv < avg && (avg - nearv) > thr) begin
      r = AX_BELOW;
    end
    cmp3 = r;
  endfunction

endpackage

`default_nettype wire

### hdl/tracked_box_motion_classifier.sv
`default_nettype none

// Motion classifier for one tracked box. Each input transaction carries one
// frame; each frame gives exactly one output transaction with a 9-way
// direction. Frame history lives in a ring of HISTORY_DEPTH cells that is
// rotated one place per cycle past the head cell, where all sums and vote
// counts are taken. A frame enters the ring; once the ring has filled, there
// follow a scan of the ring, three divisions on the shared serial divider
// (the two window averages and the x threshold), three reciprocal
// multiplications (the two weighted means and the area threshold), a
// decision, and with smoothing on a second scan plus a vote. A new frame is
// taken only after the last one has gone through these steps and its result
// has moved to the output register. Until the ring has filled, a frame skips
// the scan and yields stay. A new frame is taken as soon as the block is
// idle, even while the last result still waits. Configuration writes are
// taken in any cycle outside reset and must only be made when idle.

module tracked_box_motion_classifier
  import tbmc_pkg::*;
#(
  parameter int HISTORY_DEPTH = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire [11:0]  x_position,
  input  wire [11:0]  box_width,
  input  wire [23:0]  box_area,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [3:0]  direction,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire [2:0]   cfg_index,
  input  wire [5:0]   cfg_data
);

  localparam int STEPS = HISTORY_DEPTH * ((MIN_SCAN + HISTORY_DEPTH - 1) / HISTORY_DEPTH);
  localparam int TW    = $clog2(STEPS) + 1;
  localparam int FW    = $clog2(HISTORY_DEPTH + 1);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_SCAN_A    = 4'd1;
  localparam logic [3:0] ST_DIV_START = 4'd2;
  localparam logic [3:0] ST_DIV_WAIT  = 4'd3;
  localparam logic [3:0] ST_DECIDE    = 4'd4;
  localparam logic [3:0] ST_SCAN_B    = 4'd5;
  localparam logic [3:0] ST_VOTE      = 4'd6;
  localparam logic [3:0] ST_WAIT      = 4'd7;

  localparam logic [2:0] DV_XMEAN = 3'd0;
  localparam logic [2:0] DV_XAVG  = 3'd1;
  localparam logic [2:0] DV_XTHR  = 3'd2;
  localparam logic [2:0] DV_AMEAN = 3'd3;
  localparam logic [2:0] DV_AAVG  = 3'd4;
  localparam logic [2:0] DV_ATHR  = 3'd5;

  // Configuration registers.
  logic [4:0] x_count;
  logic [3:0] x_delay;
  logic [4:0] a_count;
  logic [3:0] a_delay;
  logic [5:0] vote_span;
  logic       smoothing_on;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_count      <= 5'd5;
      x_delay      <= 4'd5;
      a_count      <= 5'd5;
      a_delay      <= 4'd5;
      vote_span    <= 6'd15;
      smoothing_on <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_X_COUNT:    x_count      <= cfg_data[4:0];
        CFG_X_DELAY:    x_delay      <= cfg_data[3:0];
        CFG_AREA_COUNT: a_count      <= cfg_data[4:0];
        CFG_AREA_DELAY: a_delay      <= cfg_data[3:0];
        CFG_VOTE_SPAN:  vote_span    <= cfg_data;
        CFG_SMOOTHING:  smoothing_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [3:0]    state;
  logic [TW-1:0] t;
  logic [2:0]    div_sel;
  logic [FW-1:0] frames_seen;
  logic          ring_full;
  logic [3:0]    result;
  logic [3:0]    dir_cur;
  logic          in_fire;
  logic          out_free;

  assign in_ready = (state == ST_IDLE) && !rst;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // The ring of cells; age k sits in cell k between scans.
  cell_data_t cell_q [HISTORY_DEPTH];
  cell_data_t new_d;

  assign new_d = '{x: x_position, w: box_width, a: box_area, dir: DIR_STAY};

  genvar k;
  generate
    for (k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
      cell_ctl_t ctl;
      assign ctl.shift   = in_fire;
      assign ctl.rotate  = (state == ST_SCAN_A) || (state == ST_SCAN_B);
      assign ctl.set_dir = (state == ST_DECIDE) && (k == 0);
      tbmc_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctl),
        .shift_d ((k == 0) ? new_d : cell_q[(k + HISTORY_DEPTH - 1) % HISTORY_DEPTH]),
        .rot_d   (cell_q[(k + 1) % HISTORY_DEPTH]),
        .dir_new (dir_cur),
        .q       (cell_q[k])
      );
    end
  endgenerate

  // Effective window counts and bounds in scan steps.
  logic [4:0]    xc;
  logic [4:0]    ac;
  logic [TW-1:0] x_lo, x_hi, a_lo, a_hi;
  logic          in_xwin, in_awin, in_near;
  logic [2:0]    wgt;
  logic [14:0]   x_w;
  logic [26:0]   a_w;

  assign xc      = (x_count == 5'd0) ? 5'd1 : x_count;
  assign ac      = (a_count == 5'd0) ? 5'd1 : a_count;
  assign x_lo    = TW'(x_delay) + TW'(1);
  assign x_hi    = TW'(x_delay) + TW'(xc);
  assign a_lo    = TW'(a_delay) + TW'(1);
  assign a_hi    = TW'(a_delay) + TW'(ac);
  assign in_xwin = (t >= x_lo) && (t <= x_hi);
  assign in_awin = (t >= a_lo) && (t <= a_hi);
  assign in_near = (t < TW'(NEAR_TAPS));
  assign wgt     = 3'(NEAR_TAPS) - t[2:0];
  assign x_w     = 15'(cell_q[0].x) * 15'(wgt);
  assign a_w     = 27'(cell_q[0].a) * 27'(wgt);

  // Accumulators and division results.
  logic [15:0] xnear;
  logic [27:0] anear;
  logic [16:0] xsum, wsum;
  logic [28:0] asum;
  logic [11:0] xm, xavg, xthr;
  logic [23:0] am, aavg, athr;
  logic [5:0]  cnt_l, cnt_r, cnt_f, cnt_b;

  // Shared divider, used for the divisions by a window count.
  logic                 div_start;
  logic                 div_busy;
  logic [DIV_W-1:0]     div_q;
  logic [DIV_W-1:0]     div_n;
  logic [DIVISOR_W-1:0] div_d;
  logic                 div_serial;

  // Divisions by a constant go through a reciprocal multiplication instead.
  logic [31:0] rc_n;
  logic [31:0] rc_m;
  logic [63:0] rc_p;
  logic [23:0] rc_q;

  always_comb begin
    div_serial = 1'b0;
    rc_n       = '0;
    rc_m       = RECIP15;
    case (div_sel)
      DV_XMEAN: rc_n = 32'(xnear);
      DV_AMEAN: rc_n = 32'(anear);
      DV_ATHR: begin
        rc_n = 32'(aavg >> AREA_PRE_SH);
        rc_m = RECIP5;
      end
      default: div_serial = 1'b1;
    endcase
  end

  assign rc_p = 64'(rc_n) * 64'(rc_m);
  assign rc_q = (div_sel == DV_ATHR) ? rc_p[RECIP5_SH +: 24] : rc_p[RECIP15_SH +: 24];

  assign div_start = (state == ST_DIV_START) && div_serial;

  always_comb begin
    case (div_sel)
      DV_XAVG:  begin div_n = DIV_W'(xsum);               div_d = xc;            end
      DV_XTHR:  begin div_n = DIV_W'(wsum >> THR_SHIFT);  div_d = xc;            end
      DV_AAVG:  begin div_n = asum;                       div_d = ac;            end
      default:  begin div_n = '0;                         div_d = DIVISOR_W'(1); end
    endcase
  end

  tbmc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Decision for the current frame and for the vote.
  logic [5:0] half;
  logic [1:0] vote_lr, vote_fb;

  assign dir_cur = dir_of(cmp3(24'(xm), 24'(xavg), 24'(xthr)), cmp3(am, aavg, athr));
  assign half    = vote_span >> 1;
  assign vote_lr = (cnt_l > half) ? AX_ABOVE : (cnt_r > half) ? AX_BELOW : AX_NONE;
  assign vote_fb = (cnt_f > half) ? AX_ABOVE : (cnt_b > half) ? AX_BELOW : AX_NONE;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      frames_seen <= '0;
      ring_full   <= 1'b0;
      t           <= '0;
      div_sel     <= DV_XMEAN;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            t <= '0;
            if (frames_seen < FW'(HISTORY_DEPTH)) begin
              frames_seen <= frames_seen + FW'(1);
            end
            if (ring_full || (frames_seen >= FW'(HISTORY_DEPTH - 1))) begin
              ring_full <= 1'b1;
              state     <= ST_SCAN_A;
            end else begin
              state <= ST_WAIT;
            end
          end
        end
        ST_SCAN_A: begin
          t <= t + TW'(1);
          if (t == TW'(STEPS - 1)) begin
            div_sel <= DV_XMEAN;
            state   <= ST_DIV_START;
          end
        end
        ST_DIV_START: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (!div_busy) begin
            if (div_sel == DV_ATHR) begin
              state <= ST_DECIDE;
            end else begin
              div_sel <= div_sel + 3'd1;
              state   <= ST_DIV_START;
            end
          end
        end
        ST_DECIDE: begin
          t     <= '0;
          state <= smoothing_on ? ST_SCAN_B : ST_WAIT;
        end
        ST_SCAN_B: begin
          t <= t + TW'(1);
          if (t == TW'(STEPS - 1)) begin
            state <= ST_VOTE;
          end
        end
        ST_VOTE: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        xnear  <= '0;
        anear  <= '0;
        xsum   <= '0;
        wsum   <= '0;
        asum   <= '0;
        cnt_l  <= '0;
        cnt_r  <= '0;
        cnt_f  <= '0;
        cnt_b  <= '0;
        result <= DIR_STAY;
      end
      ST_SCAN_A: begin
        if (in_near) begin
          xnear <= xnear + 16'(x_w);
          anear <= anear + 28'(a_w);
        end
        if (in_xwin) begin
          xsum <= xsum + 17'(cell_q[0].x);
          wsum <= wsum + 17'(cell_q[0].w);
        end
        if (in_awin) begin
          asum <= asum + 29'(cell_q[0].a);
        end
      end
      ST_DIV_WAIT: begin
        if (!div_busy) begin
          case (div_sel)
            DV_XMEAN: xm   <= rc_q[11:0];
            DV_XAVG:  xavg <= div_q[11:0];
            DV_XTHR:  xthr <= div_q[11:0];
            DV_AMEAN: am   <= rc_q;
            DV_AAVG:  aavg <= div_q[23:0];
            DV_ATHR:  athr <= rc_q;
            default: ;
          endcase
        end
      end
      ST_DECIDE: begin
        result <= dir_cur;
      end
      ST_SCAN_B: begin
        if (t < TW'(vote_span)) begin
          if (lr_of(cell_q[0].dir) == AX_ABOVE) begin
            cnt_l <= cnt_l + 6'd1;
          end else if (lr_of(cell_q[0].dir) == AX_BELOW) begin
            cnt_r <= cnt_r + 6'd1;
          end
          if (fb_of(cell_q[0].dir) == AX_ABOVE) begin
            cnt_f <= cnt_f + 6'd1;
          end else if (fb_of(cell_q[0].dir) == AX_BELOW) begin
            cnt_b <= cnt_b + 6'd1;
          end
        end
      end
      ST_VOTE: begin
        result <= dir_of(vote_lr, vote_fb);
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_WAIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WAIT && out_free) begin
      direction <= result;
    end
  end

  // Before the ring has filled, every transaction reports stay.
  a_stay_until_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ring_full |-> direction == DIR_STAY)
    else $error("direction other than stay before the ring filled");

  // A delivered direction is always a defined code.
  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> direction <= DIR_RIGHTBACK)
    else $error("undefined direction code delivered");

  // The divider only runs while the sequencer waits on it.
  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == ST_DIV_WAIT)
    else $error("divider busy outside its wait state");

  // The frame counter saturates at the ring depth.
  a_frames_sat: assert property (@(posedge clk) disable iff (rst)
    frames_seen <= FW'(HISTORY_DEPTH))
    else $error("frame counter passed the ring depth");

endmodule

`default_nettype wire

### hdl/tbmc_cell.sv
`default_nettype none

module tbmc_cell
  import tbmc_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  cell_ctl_t  ctl,
  input  cell_data_t shift_d,
  input  cell_data_t rot_d,
  input  wire [3:0]  dir_new,
  output cell_data_t q
);

  always_ff @(posedge clk) begin
    // Frame payload: shift on a new frame, rotate during a scan.
    if (ctl.shift) begin
      q.x <= shift_d.x;
      q.w <= shift_d.w;
      q.a <= shift_d.a;
    end else if (ctl.rotate) begin
      q.x <= rot_d.x;
      q.w <= rot_d.w;
      q.a <= rot_d.a;
    end
    // Stored direction resets to stay.
    if (rst) begin
      q.dir <= DIR_STAY;
    end else if (ctl.shift) begin
      q.dir <= shift_d.dir;
    end else if (ctl.rotate) begin
      q.dir <= rot_d.dir;
    end else if (ctl.set_dir) begin
      q.dir <= dir_new;
    end
  end

endmodule

`default_nettype wire

### hdl/tbmc_div.sv
`default_nettype none

module tbmc_div
  import tbmc_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire [DIV_W-1:0]     dividend,
  input  wire [DIVISOR_W-1:0] divisor,
  output logic                busy,
  output logic [DIV_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;

  // One quotient bit per cycle, restoring scheme.
  assign trial = {rem, quotient[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      rem      <= fits ? DIVISOR_W'(trial - {1'b0, dvs}) : trial[DIVISOR_W-1:0];
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

### dv/tracked_box_motion_classifier_tb.sv
`timescale 1ns / 1ps

module tracked_box_motion_classifier_tb;
  import tbmc_pkg::*;

  localparam int DEPTH = 32;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [11:0] x_position;
  logic [11:0] box_width;
  logic [23:0] box_area;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  direction;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [5:0]  cfg_data;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] w;
    logic [23:0] a;
  } frame_t;

  tracked_box_motion_classifier #(.HISTORY_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .x_position(x_position), .box_width(box_width), .box_area(box_area),
    .out_valid(out_valid), .out_ready(out_ready), .direction(direction),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Predictor state: register copies and the frame ring.
  logic [4:0]  xw_count, aw_count;
  logic [3:0]  xw_delay, aw_delay;
  logic [5:0]  span;
  logic        smooth;
  logic [11:0] ring_x [DEPTH];
  logic [11:0] ring_w [DEPTH];
  logic [23:0] ring_a [DEPTH];
  logic [3:0]  ring_dir [DEPTH];
  int          head_slot;
  int          frame_count;

  frame_t      frame_q[$];
  logic [3:0]  direction_q[$];
  int          errors;
  int          frames_sent;
  int          results_seen;
  int          cfg_writes;
  bit          hold_off;
  bit          sender_pause;
  bit          in_taken;
  int          hold_left;

  function automatic int prev_slot(input int i);
    return (i + DEPTH - 1) % DEPTH;
  endfunction

  function automatic logic [1:0] compare_axis(input longint nearv, input longint avg,
                                              input longint thr);
    if (nearv > avg && nearv - avg > thr) return AX_ABOVE;
    if (nearv < avg && avg - nearv > thr) return AX_BELOW;
    return AX_NONE;
  endfunction

  function automatic logic [3:0] combine_axes(input logic [1:0] lr, input logic [1:0] fb);
    case (lr)
      AX_ABOVE: return (fb == AX_ABOVE) ? DIR_LEFTFRONT :
                       (fb == AX_BELOW) ? DIR_LEFTBACK : DIR_LEFT;
      AX_BELOW: return (fb == AX_ABOVE) ? DIR_RIGHTFRONT :
                       (fb == AX_BELOW) ? DIR_RIGHTBACK : DIR_RIGHT;
      default:  return (fb == AX_ABOVE) ? DIR_FRONT :
                       (fb == AX_BELOW) ? DIR_BACK : DIR_STAY;
    endcase
  endfunction

  // Push one frame into the predictor ring and compute its direction.
  function automatic logic [3:0] classify_frame(input frame_t f);
    int     s, i, j, xc, ac, cl, cr, cf, cb, half;
    longint xs, ws, as_, xnear, anear, xavg, aavg;
    logic [1:0] lr, fb;
    logic [3:0] d;
    s = (head_slot + 1) % DEPTH;
    head_slot = s;
    ring_x[s] = f.x;
    ring_w[s] = f.w;
    ring_a[s] = f.a;
    if (frame_count < DEPTH) frame_count++;
    if (frame_count < DEPTH) begin
      ring_dir[s] = DIR_STAY;
      return DIR_STAY;
    end
    xc = (xw_count == 0) ? 1 : xw_count;
    ac = (aw_count == 0) ? 1 : aw_count;
    // Weighted mean of the five newest frames.
    xnear = 0;
    anear = 0;
    i = s;
    for (j = 5; j >= 1; j--) begin
      xnear += j * longint'(ring_x[i]);
      anear += j * longint'(ring_a[i]);
      i = prev_slot(i);
    end
    xnear /= 15;
    anear /= 15;
    // Delayed reference windows.
    xs = 0;
    ws = 0;
    i = s;
    for (j = 0; j <= xw_delay; j++) i = prev_slot(i);
    for (j = 0; j < xc; j++) begin
      xs += ring_x[i];
      ws += ring_w[i];
      i = prev_slot(i);
    end
    xavg = xs / xc;
    lr = compare_axis(xnear, xavg, ws / (8 * xc));
    as_ = 0;
    i = s;
    for (j = 0; j <= aw_delay; j++) i = prev_slot(i);
    for (j = 0; j < ac; j++) begin
      as_ += ring_a[i];
      i = prev_slot(i);
    end
    aavg = as_ / ac;
    fb = compare_axis(anear, aavg, aavg / 20);
    d = combine_axes(lr, fb);
    ring_dir[s] = d;
    if (!smooth) return d;
    // Majority vote over recent stored directions.
    cl = 0; cr = 0; cf = 0; cb = 0;
    i = s;
    for (j = 0; j < span; j++) begin
      case (ring_dir[i])
        DIR_LEFT, DIR_LEFTFRONT, DIR_LEFTBACK:    cl++;
        DIR_RIGHT, DIR_RIGHTFRONT, DIR_RIGHTBACK: cr++;
        default: ;
      endcase
      case (ring_dir[i])
        DIR_FRONT, DIR_LEFTFRONT, DIR_RIGHTFRONT: cf++;
        DIR_BACK, DIR_LEFTBACK, DIR_RIGHTBACK:    cb++;
        default: ;
      endcase
      i = prev_slot(i);
    end
    half = span / 2;
    lr = (cl > half) ? AX_ABOVE : (cr > half) ? AX_BELOW : AX_NONE;
    fb = (cf > half) ? AX_ABOVE : (cb > half) ? AX_BELOW : AX_NONE;
    return combine_axes(lr, fb);
  endfunction

  // Driver: bursts of frames separated by random gaps. An offered frame is
  // held until the rising edge that accepts it has been seen.
  int burst_left;
  int gap_left;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (in_valid && !in_taken) begin
      // Hold the offered frame until it is taken.
    end else begin
      in_taken = 1'b0;
      if (sender_pause || frame_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        {x_position, box_width, box_area} <= frame_q[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 400);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Acceptance happens at the rising edge; predict there.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      direction_q.push_back(classify_frame(frame_q.pop_front()));
      frames_sent++;
      in_taken = 1'b1;
    end
  end

  // Receiver stall pattern, with a long hold-off counted here on request.
  int stall_phase;
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_phase <= 0;
      hold_left <= 0;
    end else if (hold_off) begin
      hold_off = 1'b0;
      hold_left <= 3000;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 512 < 128) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    logic [3:0] want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (direction_q.size() == 0) begin
        $display("%0t: unexpected direction transaction, actual %0d", $time, direction);
        errors++;
      end else begin
        want = direction_q.pop_front();
        if (direction !== want) begin
          $display("%0t: direction mismatch, expected %0d actual %0d",
                   $time, want, direction);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [5:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_X_COUNT:    xw_count = value[4:0];
      CFG_X_DELAY:    xw_delay = value[3:0];
      CFG_AREA_COUNT: aw_count = value[4:0];
      CFG_AREA_DELAY: aw_delay = value[3:0];
      CFG_VOTE_SPAN:  span = value;
      CFG_SMOOTHING:  smooth = value[0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every frame is taken and every result has come back.
  task automatic drain;
    while (frame_q.size() != 0 || in_valid || direction_q.size() != 0 || hold_left > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // Random frame whose values wander around a trend, so all directions occur.
  int trend_x, trend_a, step_x, step_a;
  function automatic frame_t trended_frame();
    frame_t f;
    if ($urandom_range(0, 15) == 0) begin
      step_x = $urandom_range(0, 200) - 100;
      step_a = $urandom_range(0, 40000) - 20000;
    end
    trend_x += step_x;
    trend_a += step_a;
    if (trend_x < 0 || trend_x > 4095) begin
      step_x = -step_x;
      trend_x = (trend_x < 0) ? 0 : 4095;
    end
    if (trend_a < 0 || trend_a > 16777215) begin
      step_a = -step_a;
      trend_a = (trend_a < 0) ? 0 : 16777215;
    end
    f.x = 12'(trend_x + $urandom_range(0, 20));
    f.w = $urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 800));
    f.a = 24'(trend_a + $urandom_range(0, 2000));
    if ($urandom_range(0, 19) == 0) f = {12'($urandom), 12'($urandom), 24'($urandom)};
    return f;
  endfunction

  task automatic random_phase(input int n);
    repeat (n) frame_q.push_back(trended_frame());
  endtask

  initial begin
    int p;
    int mark;
    errors = 0; frames_sent = 0; results_seen = 0; cfg_writes = 0;
    hold_off = 0; sender_pause = 0;
    trend_x = 2000; trend_a = 8000000; step_x = 40; step_a = 50000;
    in_valid = 0; x_position = 0; box_width = 0; box_area = 0;
    out_ready = 0; cfg_valid = 0; cfg_index = CFG_X_COUNT; cfg_data = 0;
    xw_count = 5; xw_delay = 5; aw_count = 5; aw_delay = 5; span = 15; smooth = 1;
    head_slot = DEPTH - 1;
    frame_count = 0;
    for (int i = 0; i < DEPTH; i++) ring_dir[i] = DIR_STAY;
    rst = 1;
    repeat (2) @(posedge clk);
    rst <= 0;

    // Directed: extremes of every field and a ramp, then random frames that fill the ring.
    frame_q.push_back({12'h000, 12'h000, 24'h000000});
    frame_q.push_back({12'hfff, 12'hfff, 24'hffffff});
    frame_q.push_back({12'hfff, 12'h000, 24'h000000});
    frame_q.push_back({12'h000, 12'hfff, 24'hffffff});
    for (int i = 0; i < 21; i++)
      frame_q.push_back({12'(i * 190), 12'(i * 7), 24'(i * 700000)});
    random_phase(40);
    drain();

    // Settings sweep, including extremes, a zero window and zero vote span.
    for (p = 0; p < 10; p++) begin
      case (p)
        0: begin
          write_reg(CFG_SMOOTHING, 6'd0);
          write_reg(CFG_X_COUNT, 6'd1); write_reg(CFG_X_DELAY, 6'd0);
          write_reg(CFG_AREA_COUNT, 6'd1); write_reg(CFG_AREA_DELAY, 6'd0);
        end
        1: begin
          write_reg(CFG_X_COUNT, 6'd16); write_reg(CFG_X_DELAY, 6'd15);
          write_reg(CFG_AREA_COUNT, 6'd16); write_reg(CFG_AREA_DELAY, 6'd15);
          write_reg(CFG_SMOOTHING, 6'd1); write_reg(CFG_VOTE_SPAN, 6'd32);
        end
        2: begin
          write_reg(CFG_X_COUNT, 6'd0); write_reg(CFG_AREA_COUNT, 6'd31);
          write_reg(CFG_VOTE_SPAN, 6'd0);
        end
        3: begin
          write_reg(CFG_VOTE_SPAN, 6'd63); write_reg(CFG_X_DELAY, 6'd3);
          write_reg(CFG_AREA_DELAY, 6'd8); write_reg(CFG_X_COUNT, 6'd8);
        end
        4: begin
          write_reg(CFG_VOTE_SPAN, 6'd1); write_reg(CFG_AREA_COUNT, 6'd4);
        end
        default: begin
          write_reg(CFG_X_COUNT, 6'($urandom_range(1, 16)));
          write_reg(CFG_X_DELAY, 6'($urandom_range(0, 15)));
          write_reg(CFG_AREA_COUNT, 6'($urandom_range(1, 16)));
          write_reg(CFG_AREA_DELAY, 6'($urandom_range(0, 15)));
          write_reg(CFG_VOTE_SPAN, 6'($urandom_range(1, 32)));
          write_reg(CFG_SMOOTHING, 6'($urandom_range(0, 1)));
        end
      endcase
      random_phase(165);
      if (p == 4) begin
        // Long receiver hold-off while the sender keeps offering frames.
        hold_off = 1;
      end
      if (p == 6) begin
        // Once traffic is flowing, the sender pauses until every
        // outstanding result has arrived.
        mark = frames_sent;
        while (frames_sent < mark + 60) @(posedge clk);
        sender_pause = 1;
        while (direction_q.size() != 0 || in_valid) @(posedge clk);
        repeat (50) @(posedge clk);
        sender_pause = 0;
      end
      drain();
    end

    $display("Covered %0d frames, %0d results, %0d register writes over 11 settings.",
             frames_sent, results_seen, cfg_writes);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #8000000;
    $display("Timeout with %0d results outstanding.", direction_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
